@@ hw/rtl/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg
// types and constants of the first-fit range allocator
// ----------------------------------------------------------------------------
package ffra_pkg;
  localparam int RANGE_SLOTS_DEF = 64;
  localparam int INDEX_BITS_DEF  = 16;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic CFG_HEAP_SIZE     = 1'b0;
  localparam logic CFG_HEAP_ATTACHED = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] block_start;
    logic [16:0] block_count;
    logic        same_heap;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alloc_start;
    logic [16:0] alloc_count;
    logic [16:0] free_total;
  } out_item_t;
endpackage

@@ hw/rtl/ffra_ram.sv @@
// ----------------------------------------------------------------------------
// ffra_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/first_fit_range_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_range_allocator_unit
// first-fit allocator over a table of free ranges with coalescing on free
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       in         start & !busy        in_item (cmd, block, same_heap)
// out      out        out_strobe, 1 cycle  out_item (status, grant, total)
// cfg      in         cfg_valid&cfg_ready  cfg_index, cfg_data
//
// one command at a time. alloc and free scan used entries through the
// range memory, one per cycle, read the last entry, then write back at
// most two entries, two only for a free that merges on both sides. an
// alloc stops scanning at its first fit. reset and rejected commands go
// straight from idle to the result.
// synchronous reset leaves one full range; no clearing pass.
// results cannot be stalled.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_unit #(
  parameter int RANGE_SLOTS = ffra_pkg::RANGE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffra_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output ffra_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [16:0]         cfg_data
);
  import ffra_pkg::*;

  localparam int AW = $clog2(RANGE_SLOTS);
  localparam int CW = $clog2(RANGE_SLOTS + 1);
  localparam logic [16:0] LIMIT = 17'(1 << INDEX_BITS_DEF);

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DONE = 3'd2,
                         S_LAST = 3'd3, S_WB1 = 3'd4, S_WB2 = 3'd5,
                         S_OUT  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [16:0] heap_size_r;
  logic        attached_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [16:0] free_r, free_nxt;
  logic        e0_ok_r, e0_ok_nxt;
  logic [16:0] e0_len_r, e0_len_nxt;
  in_item_t    req_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic        rvalid_r, rvalid_nxt;
  logic [CW-1:0] ridx_r, ridx_nxt;
  logic        hl_r, hl_nxt, hr_r, hr_nxt, hit_r, hit_nxt;
  logic [AW-1:0] li_r, li_nxt, ri_r, ri_nxt;
  logic [15:0] lf_r, lf_nxt;
  logic [16:0] ll_r, ll_nxt, rl_r, rl_nxt;
  logic [15:0] lastf_r, lastf_nxt;
  logic [16:0] lastl_r, lastl_nxt;
  out_item_t   res_r, res_nxt;
  logic        strobe_r;

  logic          we;
  logic [AW-1:0] addr;
  logic [15:0]   wfirst, rfirst_raw, rfirst;
  logic [16:0]   wlen, rlen_raw, rlen;
  logic [16:0]   eff, fend, left_end;

  ffra_ram #(.WIDTH(16), .DEPTH(RANGE_SLOTS)) u_first (
    .clk, .we, .addr, .wdata(wfirst), .rdata(rfirst_raw));
  ffra_ram #(.WIDTH(17), .DEPTH(RANGE_SLOTS)) u_len (
    .clk, .we, .addr, .wdata(wlen), .rdata(rlen_raw));

  assign eff = (heap_size_r > LIMIT) ? LIMIT : heap_size_r;
  // entry 0 after reset reads as a full range until it is written
  assign rfirst = (ridx_r == '0 && !e0_ok_r) ? 16'd0    : rfirst_raw;
  assign rlen   = (ridx_r == '0 && !e0_ok_r) ? e0_len_r : rlen_raw;
  assign fend     = 17'(req_r.block_start) + req_r.block_count;
  assign left_end = 17'(rfirst) + rlen;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_strobe = strobe_r;
  assign out_item   = res_r;

  always_comb begin
    state_nxt = state_r; used_nxt = used_r; free_nxt = free_r;
    e0_ok_nxt = e0_ok_r; e0_len_nxt = e0_len_r;
    idx_nxt = idx_r; rvalid_nxt = 1'b0; ridx_nxt = ridx_r;
    hl_nxt = hl_r; hr_nxt = hr_r; hit_nxt = hit_r; li_nxt = li_r; ri_nxt = ri_r;
    lf_nxt = lf_r; ll_nxt = ll_r; rl_nxt = rl_r;
    lastf_nxt = lastf_r; lastl_nxt = lastl_r; res_nxt = res_r;
    we = 1'b0; addr = idx_r[AW-1:0]; wfirst = '0; wlen = '0;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0; hl_nxt = 1'b0; hr_nxt = 1'b0; hit_nxt = 1'b0;
        res_nxt = '0;
        res_nxt.status = ST_REJECTED;
        if (start) begin
          state_nxt = S_OUT;
          if (attached_r) begin
            case (in_item.cmd)
              CMD_ALLOC: if (in_item.block_count != '0) state_nxt = S_SCAN;
              CMD_FREE: begin
                if (in_item.same_heap && in_item.block_count != '0 &&
                    (18'(in_item.block_start) + 18'(in_item.block_count)) <= 18'(eff))
                  state_nxt = S_SCAN;
              end
              CMD_RESET: begin
                used_nxt = CW'(1); free_nxt = eff; e0_ok_nxt = 1'b0;
                e0_len_nxt = eff;
                res_nxt.status = ST_OK;
              end
              default: ;
            endcase
          end
        end
        res_nxt.free_total = (start && attached_r && in_item.cmd == CMD_RESET)
                             ? eff : free_r;
      end
      S_SCAN: begin
        // issue one read per cycle, evaluate the previous read
        if (idx_r < used_r && !hit_r) begin
          addr = idx_r[AW-1:0]; rvalid_nxt = 1'b1; ridx_nxt = idx_r;
          idx_nxt = idx_r + CW'(1);
        end
        if (rvalid_r) begin
          if (req_r.cmd == CMD_ALLOC) begin
            if (!hit_r && rlen >= req_r.block_count) begin
              hit_nxt = 1'b1; li_nxt = ridx_r[AW-1:0];
              lf_nxt = rfirst; ll_nxt = rlen;
            end
          end else if (left_end == 17'(req_r.block_start)) begin
            hl_nxt = 1'b1; li_nxt = ridx_r[AW-1:0]; ll_nxt = rlen;
          end else if (17'(rfirst) == fend) begin
            hr_nxt = 1'b1; ri_nxt = ridx_r[AW-1:0]; rl_nxt = rlen;
          end
        end
        if (!(idx_r < used_r && !hit_r) && !rvalid_r) state_nxt = S_DONE;
        if (hit_r) rvalid_nxt = 1'b0;
      end
      S_DONE: begin
        // read last entry for a possible replacement
        addr = AW'(used_r - CW'(1)); ridx_nxt = used_r - CW'(1);
        state_nxt = S_LAST;
      end
      S_LAST: begin
        lastf_nxt = rfirst; lastl_nxt = rlen; state_nxt = S_WB1;
      end
      S_WB1: begin
        state_nxt = S_OUT;
        if (req_r.cmd == CMD_ALLOC) begin
          if (!hit_r) res_nxt.status = ST_NO_FIT;
          else begin
            we = 1'b1; addr = li_r;
            if (ll_r == req_r.block_count) begin
              wfirst = lastf_r; wlen = lastl_r; used_nxt = used_r - CW'(1);
            end else begin
              wfirst = lf_r + req_r.block_count[15:0];
              wlen = ll_r - req_r.block_count;
            end
            free_nxt = (free_r >= req_r.block_count) ? free_r - req_r.block_count : '0;
            res_nxt.status = ST_OK; res_nxt.alloc_start = lf_r;
            res_nxt.alloc_count = req_r.block_count;
          end
        end else begin
          res_nxt.status = ST_OK;
          if (hl_r) begin
            we = 1'b1; addr = li_r;
            wfirst = lf_r;
            wlen = ll_r + req_r.block_count + (hr_r ? rl_r : 17'd0);
            if (hr_r) state_nxt = S_WB2;
          end else if (hr_r) begin
            we = 1'b1; addr = ri_r; wfirst = req_r.block_start;
            wlen = rl_r + req_r.block_count;
          end else if (used_r >= CW'(RANGE_SLOTS)) begin
            res_nxt.status = ST_FULL;
          end else begin
            we = 1'b1; addr = used_r[AW-1:0]; wfirst = req_r.block_start;
            wlen = req_r.block_count; used_nxt = used_r + CW'(1);
          end
          if (res_nxt.status == ST_OK)
            free_nxt = (18'(free_r) + 18'(req_r.block_count) > 18'(LIMIT)) ? LIMIT
                       : free_r + req_r.block_count;
        end
        if (we && addr == '0) e0_ok_nxt = 1'b1;
        res_nxt.free_total = free_nxt;
      end
      S_WB2: begin
        we = 1'b1; addr = ri_r; wfirst = lastf_r; wlen = lastl_r;
        // the last entry is the merged left one, take its new contents
        if (li_r == AW'(used_r - CW'(1))) begin
          wfirst = lf_r; wlen = ll_r + req_r.block_count + rl_r;
        end
        used_nxt = used_r - CW'(1);
        if (ri_r == '0) e0_ok_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // the left entry's first index is only known after its read
    if (state_r == S_SCAN && rvalid_r && req_r.cmd == CMD_FREE &&
        left_end == 17'(req_r.block_start)) lf_nxt = rfirst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; heap_size_r <= '0; attached_r <= 1'b0;
      used_r <= CW'(1); free_r <= '0; e0_ok_r <= 1'b0; e0_len_r <= '0;
      rvalid_r <= 1'b0; strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt; used_r <= used_nxt; free_r <= free_nxt;
      e0_ok_r <= e0_ok_nxt; e0_len_r <= e0_len_nxt; rvalid_r <= rvalid_nxt;
      strobe_r <= (state_nxt == S_OUT);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HEAP_SIZE) heap_size_r <= cfg_data;
        else attached_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req_r <= in_item;
    idx_r <= idx_nxt; ridx_r <= ridx_nxt; hl_r <= hl_nxt; hr_r <= hr_nxt;
    hit_r <= hit_nxt; li_r <= li_nxt; ri_r <= ri_nxt; lf_r <= lf_nxt;
    ll_r <= ll_nxt; rl_r <= rl_nxt; lastf_r <= lastf_nxt;
    lastl_r <= lastl_nxt; res_r <= res_nxt;
  end

`ifndef SYNTH
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(RANGE_SLOTS)) else $error("range count overflow");
  a_free_limit: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= LIMIT) else $error("free total above limit");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result outside a command");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_WB1 || state_r == S_WB2)) else $error("stray write");
`endif
endmodule

@@ test/tb_first_fit_range_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_range_allocator_unit
// self-checking bench for the first-fit range allocator: a scoreboard keeps
// its own free-range table, predicts every result and compares it field by
// field; stimulus mixes directed corner cases, well-formed alloc/free
// traffic over live blocks, fragmentation runs that fill the table, and noise
// ----------------------------------------------------------------------------
module tb_first_fit_range_allocator_unit;
  import ffra_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int HEAP_LIMIT  = 65536;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 80;

  class alloc_scoreboard;
    int unsigned heap_size;
    bit          attached;
    int unsigned range_base[TABLE_DEPTH];
    int unsigned range_len[TABLE_DEPTH];
    int unsigned used;
    int unsigned free_slots;
    out_item_t   expected_q[$];
    int unsigned live_start[$];
    int unsigned live_count[$];
    int          errors;

    function int unsigned usable_size();
      return heap_size > HEAP_LIMIT ? HEAP_LIMIT : heap_size;
    endfunction

    function void rebuild();
      range_base[0] = 0;
      range_len[0]  = usable_size();
      used          = 1;
      free_slots    = usable_size();
      live_start.delete();
      live_count.delete();
    endfunction

    function void write_reg(logic idx, int unsigned value);
      if (idx == CFG_HEAP_SIZE) heap_size = value & 32'h1FFFF;
      else attached = value[0];
    endfunction

    function void note_command(in_item_t it);
      out_item_t   res;
      int unsigned cnt, fstart, fend, lidx, ridx, last;
      bit          has_l, has_r;
      cnt = it.block_count;
      fstart = it.block_start;
      res = '0;
      res.status = ST_REJECTED;
      if (attached) begin
        if (it.cmd == CMD_ALLOC) begin
          if (cnt == 0) res.status = ST_REJECTED;
          else begin
            res.status = ST_NO_FIT;
            for (int i = 0; i < used; i++) begin
              if (range_len[i] >= cnt) begin
                res.status = ST_OK;
                res.alloc_start = range_base[i][15:0];
                res.alloc_count = cnt[16:0];
                live_start.push_back(range_base[i]);
                live_count.push_back(cnt);
                range_base[i] += cnt;
                range_len[i] -= cnt;
                if (range_len[i] == 0) begin
                  last = used - 1;
                  range_base[i] = range_base[last];
                  range_len[i] = range_len[last];
                  used = last;
                end
                free_slots = free_slots >= cnt ? free_slots - cnt : 0;
                break;
              end
            end
          end
        end else if (it.cmd == CMD_FREE) begin
          fend = fstart + cnt;
          if (!it.same_heap || cnt == 0 || fend > usable_size()) res.status = ST_REJECTED;
          else begin
            has_l = 0;
            has_r = 0;
            lidx = 0;
            ridx = 0;
            for (int i = 0; i < used; i++) begin
              if (range_base[i] + range_len[i] == fstart) begin
                lidx = i;
                has_l = 1;
              end else if (range_base[i] == fend) begin
                ridx = i;
                has_r = 1;
              end
            end
            res.status = ST_OK;
            if (has_l && has_r) begin
              last = used - 1;
              range_len[lidx] += cnt + range_len[ridx];
              range_base[ridx] = range_base[last];
              range_len[ridx] = range_len[last];
              used = last;
            end else if (has_l) begin
              range_len[lidx] += cnt;
            end else if (has_r) begin
              range_base[ridx] = fstart;
              range_len[ridx] += cnt;
            end else if (used >= TABLE_DEPTH) begin
              res.status = ST_FULL;
            end else begin
              range_base[used] = fstart;
              range_len[used] = cnt;
              used++;
            end
            if (res.status == ST_OK) begin
              free_slots += cnt;
              if (free_slots > HEAP_LIMIT) free_slots = HEAP_LIMIT;
            end
          end
        end else if (it.cmd == CMD_RESET) begin
          rebuild();
          res.status = ST_OK;
        end
      end
      res.free_total = free_slots[16:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.status !== exp_item.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_item.status, got.status);
        errors++;
      end
      if (got.alloc_start !== exp_item.alloc_start) begin
        $display("%0t: alloc_start expected %0d actual %0d", $time,
                 exp_item.alloc_start, got.alloc_start);
        errors++;
      end
      if (got.alloc_count !== exp_item.alloc_count) begin
        $display("%0t: alloc_count expected %0d actual %0d", $time,
                 exp_item.alloc_count, got.alloc_count);
        errors++;
      end
      if (got.free_total !== exp_item.free_total) begin
        $display("%0t: free_total expected %0d actual %0d", $time,
                 exp_item.free_total, got.free_total);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic      cfg_index = CFG_HEAP_SIZE;
  logic [16:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int  sent_items;
  bit  no_idle;
  int  quiet_cycles;

  first_fit_range_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // result check
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, int unsigned bstart,
                                         int unsigned bcount, bit same);
    in_item_t it;
    it.cmd = cmd;
    it.block_start = bstart[15:0];
    it.block_count = bcount[16:0];
    it.same_heap = same;
    return it;
  endfunction

  task automatic send_command(in_item_t it);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 30) ? $urandom_range(16, 1) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_item <= it;
    @(posedge clk iff !busy);
    sb.note_command(it);
    sent_items++;
  endtask

  // every command returns one result; wait them out before a register write
  task automatic drain();
    start <= 0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (TABLE_DEPTH + 6) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value[16:0];
    @(posedge clk iff cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned size, bit attach);
    drain();
    write_reg(CFG_HEAP_SIZE, size);
    write_reg(CFG_HEAP_ATTACHED, attach);
    send_command(make_item(CMD_RESET, 0, 0, 1));
  endtask

  // allocate single slots, then free every other one, which fills the table
  task automatic fragment(int unsigned slots);
    for (int k = 0; k < slots; k++) send_command(make_item(CMD_ALLOC, 0, 1, 1));
    for (int k = 0; k < slots; k += 2) send_command(make_item(CMD_FREE, k, 1, 1));
    send_command(make_item(CMD_RESET, 0, 0, 1));
  endtask

  task automatic traffic(int n);
    int unsigned r, size, idx;
    for (int k = 0; k < n && sent_items < 1400; k++) begin
      r = $urandom_range(99);
      size = sb.usable_size();
      if (r >= 45 && r < 85 && sb.live_start.size() > 0) begin
        idx = $urandom_range(sb.live_start.size() - 1);
        send_command(make_item(CMD_FREE, sb.live_start[idx], sb.live_count[idx], 1));
        sb.live_start.delete(idx);
        sb.live_count.delete(idx);
      end else if (r >= 85 && r < 90) begin
        send_command(make_item(CMD_FREE, $urandom_range(size > 0 ? size - 1 : 0),
                               $urandom_range(6, 1), 1));
      end else if (r >= 90 && r < 97) begin
        send_command(make_item(2'($urandom_range(3)), $urandom, $urandom & 32'h1FFFF,
                               1'($urandom_range(1))));
      end else if (r >= 97) begin
        send_command(make_item(CMD_RESET, $urandom, $urandom, 1));
      end else if ($urandom_range(9) < 8) begin
        send_command(make_item(CMD_ALLOC, 0, $urandom_range(8, 1), 1));
      end else begin
        send_command(make_item(CMD_ALLOC, $urandom, $urandom_range(size + 1), 1));
      end
    end
  endtask

  initial begin
    int unsigned size;
    sb.heap_size = 0;
    sb.attached = 0;
    sb.rebuild();
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed corner cases
    send_command(make_item(CMD_ALLOC, 0, 5, 1));
    drain();
    write_reg(CFG_HEAP_ATTACHED, 1);
    send_command(make_item(CMD_ALLOC, 0, 1, 1));
    drain();
    write_reg(CFG_HEAP_SIZE, 100);
    send_command(make_item(CMD_ALLOC, 0, 1, 1));
    send_command(make_item(CMD_RESET, 0, 0, 0));
    send_command(make_item(CMD_ALLOC, 0, 0, 1));
    send_command(make_item(CMD_ALLOC, 0, 101, 1));
    send_command(make_item(CMD_ALLOC, 0, 100, 1));
    send_command(make_item(CMD_FREE, 0, 100, 0));
    send_command(make_item(CMD_FREE, 0, 0, 1));
    send_command(make_item(CMD_FREE, 99, 2, 1));
    send_command(make_item(CMD_FREE, 40, 20, 1));
    send_command(make_item(CMD_FREE, 10, 5, 1));
    send_command(make_item(CMD_FREE, 15, 25, 1));
    send_command(make_item(CMD_FREE, 40, 20, 1));
    send_command(make_item(2'd3, 16'hFFFF, 17'h1FFFF, 1));
    configure(17'h1FFFF, 1);
    send_command(make_item(CMD_ALLOC, 16'hFFFF, 65536, 1));
    send_command(make_item(CMD_FREE, 65535, 1, 1));
    send_command(make_item(CMD_FREE, 0, 65535, 1));
    send_command(make_item(CMD_FREE, 65535, 2, 1));
    configure(65536, 0);
    send_command(make_item(CMD_RESET, 0, 0, 1));
    send_command(make_item(CMD_FREE, 0, 1, 1));

    // random phases
    while (sent_items < 1400) begin
      if (sent_items > 1200) no_idle = 1;
      case ($urandom_range(9))
        0: size = 65536;
        1: size = $urandom & 32'h1FFFF;
        2: size = $urandom_range(8);
        default: size = $urandom_range(400, 16);
      endcase
      configure(size, $urandom_range(9) != 0);
      if (size >= 140 && size <= 400 && sent_items < 1200 && $urandom_range(2) == 0)
        fragment(140);
      traffic($urandom_range(120, 40));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_ram.sv
hw/rtl/first_fit_range_allocator_unit.sv
test/tb_first_fit_range_allocator_unit.sv
